// ----- hdl/l1poc_pkg.sv -----
// Package for the L1 partition occupancy calculator.
// Holds payload structs, register indexes, status codes and divider sizes.
// No dependencies.
`default_nettype none
package l1poc_pkg;

	localparam int L1D_MAX_SETS = 256;
	localparam int N_CAND       = 5;
	localparam logic [10:0] L1D_CAND [N_CAND] = '{11'd64, 11'd128, 11'd256, 11'd512, 11'd1024};

	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SLOTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_L1D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRANULARITY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WG      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WARPS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCALAR_REGS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_REGS = 3'd7;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_LDS_OVER = 2'd1;
	localparam logic [1:0] STAT_NO_PART  = 2'd2;

	typedef struct packed {
		logic [31:0] lds_bytes;
		logic [6:0]  wg_warps;
		logic [7:0]  scalar_use;
		logic [7:0]  vector_use;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] lds_slots_per_wg;
		logic [12:0] smem_slots_per_sm;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
		logic                 rem_nz;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/l1poc_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on l1poc_pkg for widths and request/response structs.
`default_nettype none
module l1poc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire l1poc_pkg::div_req_t req,
	output l1poc_pkg::div_rsp_t    rsp
);

	logic [l1poc_pkg::DIV_NUM_W-1:0] n_q;
	logic [l1poc_pkg::DIV_DEN_W:0]   r_q;
	logic [l1poc_pkg::DIV_DEN_W-1:0] d_q;
	logic [l1poc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            act_q;
	logic                            done_q;
	logic [l1poc_pkg::DIV_DEN_W:0]   r_sh;
	logic                            fits;

	assign r_sh = {r_q[l1poc_pkg::DIV_DEN_W-1:0], n_q[l1poc_pkg::DIV_NUM_W-1]};
	assign fits = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			act_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= l1poc_pkg::DIV_CNT_W'(l1poc_pkg::DIV_NUM_W);
		end else if (act_q) begin
			cnt_q  <= cnt_q - l1poc_pkg::DIV_CNT_W'(1);
			act_q  <= cnt_q != l1poc_pkg::DIV_CNT_W'(1);
			done_q <= cnt_q == l1poc_pkg::DIV_CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.num;
			d_q <= req.den;
			r_q <= '0;
		end else if (act_q) begin
			n_q <= {n_q[l1poc_pkg::DIV_NUM_W-2:0], fits};
			r_q <= fits ? (r_sh - {1'b0, d_q}) : r_sh;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = n_q;
	assign rsp.rem_nz = r_q != '0;

endmodule
`default_nettype wire

// ----- hdl/l1_partition_occupancy_calc_core.sv -----
// Top level of the L1 partition occupancy calculator: config registers, sequencer,
// output register. Depends on l1poc_pkg and l1poc_div.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+-----------------------------
//  cfg     | cfg_valid cfg_ready cfg_index/data | cfg_valid && cfg_ready
//  in      | in_valid in_stall in_data        | in_valid && !in_stall
//  out     | out_valid out_stall out_data     | out_valid && !out_stall
//
// Every division runs on one shared 40-step divider.
// A result enters the output register after the per-workgroup LDS division when the LDS
// check rejects it, else after that division, the warp, scalar and vector divisions and one
// division per countdown trial, ending at the first trial that fits (up to 127 trials).
// in_stall is high from the transfer until the result enters the output register; a
// finished result waits while the output register stays full and out_stall is high.
// The output register frees the input side while a result waits on out_stall.
// Reset loads the register defaults and empties the output register.
`default_nettype none
module l1_partition_occupancy_calc_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [l1poc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [l1poc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire l1poc_pkg::in_item_t                  in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output l1poc_pkg::out_item_t                      out_data
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_PERWG = 8'b00000010,
		S_WARP  = 8'b00000100,
		S_SREG  = 8'b00001000,
		S_VREG  = 8'b00010000,
		S_MUL   = 8'b00100000,
		S_NEED  = 8'b01000000,
		S_EMIT  = 8'b10000000
	} state_t;

	function automatic logic [10:0] pick_l1d(input logic [12:0] room, input logic [10:0] minv,
		input logic [10:0] g);
		logic [10:0] ge;
		logic [10:0] best;
		logic        pow2;
		logic [21:0] gmax;
		ge   = (g == '0) ? 11'd1 : g;
		pow2 = (ge & (ge - 11'd1)) == '0;
		gmax = 22'(ge) * 22'(l1poc_pkg::L1D_MAX_SETS);
		best = '0;
		for (int i = 0; i < l1poc_pkg::N_CAND; i++) begin
			if (l1poc_pkg::L1D_CAND[i] >= minv && {2'b0, l1poc_pkg::L1D_CAND[i]} <= room
				&& pow2 && ge <= l1poc_pkg::L1D_CAND[i]
				&& 22'(l1poc_pkg::L1D_CAND[i]) <= gmax)
				best = l1poc_pkg::L1D_CAND[i];
		end
		return best;
	endfunction

	logic [16:0] slot_bytes_q;
	logic [12:0] total_slots_q;
	logic [10:0] min_l1d_q;
	logic [10:0] gran_q;
	logic [6:0]  max_wg_q;
	logic [6:0]  warps_sm_q;
	logic [15:0] sregs_sm_q;
	logic [15:0] vregs_sm_q;

	state_t      st_q;
	state_t      st_d;
	logic        go_q;
	logic        go_d;
	logic [31:0] lds_q;
	logic [6:0]  warps_q;
	logic [14:0] sreg_q;
	logic [14:0] vreg_q;
	logic [6:0]  res_q;
	logic [38:0] prod_q;
	logic [31:0] perwg_q;
	logic        ov_q;
	l1poc_pkg::out_item_t rslt_q;
	l1poc_pkg::out_item_t out_q;

	l1poc_pkg::div_req_t dreq;
	l1poc_pkg::div_rsp_t drsp;

	logic [16:0] sb_eff;
	logic [12:0] cap;
	logic [39:0] ceil_q;
	logic [12:0] room;
	logic [10:0] l1d;
	logic        fit;
	logic        out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = st_q != S_IDLE;
	assign out_valid = ov_q;
	assign out_data  = out_q;
	assign out_free  = !ov_q || !out_stall;

	assign sb_eff = (slot_bytes_q == '0) ? 17'd1 : slot_bytes_q;
	assign cap    = (total_slots_q > {2'b0, min_l1d_q}) ? total_slots_q - {2'b0, min_l1d_q} : '0;
	assign ceil_q = drsp.quot + 40'(drsp.rem_nz);
	assign room   = total_slots_q - ceil_q[12:0];
	assign l1d    = pick_l1d(room, min_l1d_q, gran_q);
	assign fit    = ceil_q <= 40'(total_slots_q) && l1d != '0;

	always_comb begin
		dreq.start = go_q;
		dreq.num   = {8'b0, lds_q};
		dreq.den   = sb_eff;
		case (st_q)
			S_WARP: begin
				dreq.num = {33'b0, warps_sm_q};
				dreq.den = {10'b0, warps_q};
			end
			S_SREG: begin
				dreq.num = {24'b0, sregs_sm_q};
				dreq.den = {2'b0, sreg_q};
			end
			S_VREG: begin
				dreq.num = {24'b0, vregs_sm_q};
				dreq.den = {2'b0, vreg_q};
			end
			S_NEED: begin
				dreq.num = {1'b0, prod_q};
			end
			default: begin
			end
		endcase
	end

	l1poc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q  <= 17'd128;
			total_slots_q <= 13'd1024;
			min_l1d_q     <= 11'd64;
			gran_q        <= 11'd4;
			max_wg_q      <= 7'd8;
			warps_sm_q    <= 7'd32;
			sregs_sm_q    <= 16'd4096;
			vregs_sm_q    <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				l1poc_pkg::REG_SLOT_BYTES:  slot_bytes_q  <= cfg_data;
				l1poc_pkg::REG_TOTAL_SLOTS: total_slots_q <= cfg_data[12:0];
				l1poc_pkg::REG_MIN_L1D:     min_l1d_q     <= cfg_data[10:0];
				l1poc_pkg::REG_GRANULARITY: gran_q        <= cfg_data[10:0];
				l1poc_pkg::REG_MAX_WG:      max_wg_q      <= cfg_data[6:0];
				l1poc_pkg::REG_WARPS:       warps_sm_q    <= cfg_data[6:0];
				l1poc_pkg::REG_SCALAR_REGS: sregs_sm_q    <= cfg_data[15:0];
				l1poc_pkg::REG_VECTOR_REGS: vregs_sm_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		st_d = st_q;
		go_d = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					go_d = 1'b1;
					st_d = S_PERWG;
				end
			end
			S_PERWG: begin
				if (drsp.done) begin
					if (ceil_q[31:0] > {19'b0, cap}) begin
						st_d = S_EMIT;
					end else begin
						go_d = 1'b1;
						st_d = S_WARP;
					end
				end
			end
			S_WARP: begin
				if (drsp.done) begin
					go_d = 1'b1;
					st_d = S_SREG;
				end
			end
			S_SREG: begin
				if (drsp.done) begin
					go_d = 1'b1;
					st_d = S_VREG;
				end
			end
			S_VREG: begin
				if (drsp.done)
					st_d = S_MUL;
			end
			S_MUL: begin
				if (res_q == '0) begin
					st_d = S_EMIT;
				end else begin
					go_d = 1'b1;
					st_d = S_NEED;
				end
			end
			S_NEED: begin
				if (drsp.done)
					st_d = fit ? S_EMIT : S_MUL;
			end
			S_EMIT: begin
				if (out_free)
					st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			go_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			go_q <= go_d;
			ov_q <= (st_q == S_EMIT && out_free) || (ov_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					lds_q   <= in_data.lds_bytes;
					warps_q <= in_data.wg_warps;
					sreg_q  <= 15'(in_data.wg_warps * in_data.scalar_use);
					vreg_q  <= 15'(in_data.wg_warps * in_data.vector_use);
				end
			end
			S_PERWG: begin
				if (drsp.done) begin
					perwg_q <= ceil_q[31:0];
					res_q   <= max_wg_q;
					rslt_q.status            <= l1poc_pkg::STAT_LDS_OVER;
					rslt_q.lds_slots_per_wg  <= ceil_q[31:0];
					rslt_q.smem_slots_per_sm <= '0;
				end
			end
			S_WARP: begin
				if (drsp.done && warps_q != '0 && drsp.quot < 40'(res_q))
					res_q <= drsp.quot[6:0];
			end
			S_SREG: begin
				if (drsp.done && sreg_q != '0 && drsp.quot < 40'(res_q))
					res_q <= drsp.quot[6:0];
			end
			S_VREG: begin
				if (drsp.done && vreg_q != '0 && drsp.quot < 40'(res_q))
					res_q <= drsp.quot[6:0];
			end
			S_MUL: begin
				prod_q <= 39'(res_q) * 39'(lds_q);
				rslt_q.status            <= l1poc_pkg::STAT_NO_PART;
				rslt_q.lds_slots_per_wg  <= perwg_q;
				rslt_q.smem_slots_per_sm <= '0;
			end
			S_NEED: begin
				if (drsp.done) begin
					if (fit) begin
						rslt_q.status            <= l1poc_pkg::STAT_OK;
						rslt_q.lds_slots_per_wg  <= perwg_q;
						rslt_q.smem_slots_per_sm <= total_slots_q - {2'b0, l1d};
					end else begin
						res_q <= res_q - 7'd1;
					end
				end
			end
			S_EMIT: begin
				if (out_free)
					out_q <= rslt_q;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
